// File: hw/rtl/alu3_pkg.sv
// alu3_pkg: shared types, constants and helpers of the three-operand execute unit
// no dependencies; used by the channel interfaces and every alu3 module

package alu3_pkg;

   localparam int unsigned DATA_W          = 32;
   localparam int unsigned IMM_W           = 20;
   localparam int unsigned OP_W            = 4;
   localparam int unsigned FORM_W          = 2;
   localparam int unsigned SHAMT_W         = 5;
   localparam int unsigned SMALL_IMM_BITS  = 12;
   localparam int unsigned MEDIUM_IMM_BITS = 20;
   localparam int unsigned PACK_SHIFT      = 12;
   localparam logic [DATA_W-1:0] PACK_MASK = 32'h0000_0fff;

   typedef logic [DATA_W-1:0] word_type;

   typedef enum logic [OP_W-1:0] {
      OP_ADD     = 4'd0,
      OP_SUB     = 4'd1,
      OP_MUL     = 4'd2,
      OP_SRL     = 4'd3,
      OP_SRA     = 4'd4,
      OP_SLL     = 4'd5,
      OP_LT      = 4'd6,
      OP_EQ      = 4'd7,
      OP_GE      = 4'd8,
      OP_AND     = 4'd9,
      OP_ANDN    = 4'd10,
      OP_OR      = 4'd11,
      OP_ORN     = 4'd12,
      OP_XOR     = 4'd13,
      OP_PACK    = 4'd14,
      OP_TESTBIT = 4'd15
   } op_type;

   typedef enum logic [FORM_W-1:0] {
      FORM_REG_REG_IMM  = 2'd0,
      FORM_REG_IMM_REG  = 2'd1,
      FORM_IMM_REG_REG  = 2'd2,
      FORM_ZERO_REG_IMM = 2'd3
   } form_type;

   typedef struct packed {
      op_type   op;
      word_type a;
      word_type b;
      word_type c;
   } slots_type;

   typedef struct packed {
      word_type val;
      word_type c;
   } partial_type;

   // sign extension of the raw immediate from its low n bits
   function automatic word_type sext_imm(logic [IMM_W-1:0] raw, int unsigned n);
      word_type v;
      word_type res;
      v = word_type'(raw);
      for (int i = 0; i < DATA_W; i++) begin
         res[i] = (i < n) ? v[i] : v[n-1];
      end
      return res;
   endfunction

endpackage

// File: hw/rtl/alu3_req_if.sv
// alu3_req_if: request channel of the execute unit (opcode, form, registers, immediate)
// depends on alu3_pkg for field widths

interface alu3_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [alu3_pkg::OP_W-1:0]            req_type;
   logic [alu3_pkg::FORM_W-1:0]          operand_form;
   logic signed [alu3_pkg::DATA_W-1:0]   first_reg;
   logic signed [alu3_pkg::DATA_W-1:0]   second_reg;
   logic [alu3_pkg::IMM_W-1:0]           imm_bits;

   modport source (output valid, req_type, operand_form, first_reg, second_reg, imm_bits,
                   input ready);
   modport sink   (input valid, req_type, operand_form, first_reg, second_reg, imm_bits,
                   output ready);
endinterface

// File: hw/rtl/alu3_rsp_if.sv
// alu3_rsp_if: result channel of the execute unit
// depends on alu3_pkg for field widths

interface alu3_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [alu3_pkg::DATA_W-1:0]   result;

   modport source (output valid, result, input ready);
   modport sink   (input valid, result, output ready);
endinterface

// File: hw/rtl/alu_three_operand_add_immediate.sv
// alu_three_operand_add_immediate: top level of the three-operand execute unit
// depends on alu3_pkg, alu3_req_if, alu3_rsp_if, alu3_place, alu3_exec and alu3_sum
//
// usage
//   req_chan carries one instruction per transfer: opcode, operand form, the two
//   register values and the raw immediate. rsp_chan returns one 32-bit result per
//   request, in request order, as (a op b) + c.
//   three register stages: operand placement, operation (multiplier and shifter),
//   final add. a result is offered once it reaches the final add register, having
//   passed the placement and operation registers in order.
//   throughput is one transfer per cycle while rsp_chan is taken;
//   the stage holding the multiplier and the shifter sets the clock period.
//   each stage takes a new item whenever it is empty or its successor moves, so
//   req_chan.ready stays high while rsp_chan is being taken.
//   when the receiver stalls, results stay held in the stages and requests are
//   still taken until all three stages are full; then req_chan.ready drops.
//   reset clears only the stage valid bits; the data registers are not reset.

module alu_three_operand_add_immediate (
   input  logic          clock,
   input  logic          reset,
   alu3_req_if.sink      req_chan,
   alu3_rsp_if.source    rsp_chan
);

   logic                    place_valid;
   logic                    place_ready;
   alu3_pkg::slots_type     place_slots;
   logic                    exec_valid;
   logic                    exec_ready;
   alu3_pkg::partial_type   exec_part;

   alu3_place u_place (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .out_valid (place_valid),
      .out_slots (place_slots),
      .out_ready (place_ready)
   );

   alu3_exec u_exec (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (place_valid),
      .in_slots  (place_slots),
      .in_ready  (place_ready),
      .out_valid (exec_valid),
      .out_part  (exec_part),
      .out_ready (exec_ready)
   );

   alu3_sum u_sum (
      .clock    (clock),
      .reset    (reset),
      .in_valid (exec_valid),
      .in_part  (exec_part),
      .in_ready (exec_ready),
      .rsp_chan (rsp_chan)
   );

endmodule

// File: hw/rtl/alu3_place.sv
// alu3_place: first pipeline stage, sign-extends the immediate and fills slots a, b and c
// depends on alu3_pkg and alu3_req_if

module alu3_place (
   input  logic                  clock,
   input  logic                  reset,
   alu3_req_if.sink              req_chan,
   output logic                  out_valid,
   output alu3_pkg::slots_type   out_slots,
   input  logic                  out_ready
);

   logic                  valid_ff;
   logic                  valid_in;
   alu3_pkg::slots_type   slots_ff;
   alu3_pkg::slots_type   slots_in;
   alu3_pkg::word_type    small_imm;
   alu3_pkg::word_type    wide_imm;
   logic                  advance;

   assign advance        = !valid_ff || out_ready;
   assign req_chan.ready = advance;

   always_comb begin
      small_imm    = alu3_pkg::sext_imm(req_chan.imm_bits, alu3_pkg::SMALL_IMM_BITS);
      wide_imm     = alu3_pkg::sext_imm(req_chan.imm_bits, alu3_pkg::MEDIUM_IMM_BITS);
      slots_in.op  = alu3_pkg::op_type'(req_chan.req_type);
      unique case (alu3_pkg::form_type'(req_chan.operand_form))
         alu3_pkg::FORM_REG_REG_IMM: begin
            slots_in.a = req_chan.first_reg;
            slots_in.b = req_chan.second_reg;
            slots_in.c = small_imm;
         end
         alu3_pkg::FORM_REG_IMM_REG: begin
            slots_in.a = req_chan.first_reg;
            slots_in.b = small_imm;
            slots_in.c = req_chan.second_reg;
         end
         alu3_pkg::FORM_IMM_REG_REG: begin
            slots_in.a = small_imm;
            slots_in.b = req_chan.first_reg;
            slots_in.c = req_chan.second_reg;
         end
         alu3_pkg::FORM_ZERO_REG_IMM: begin
            slots_in.a = '0;
            slots_in.b = req_chan.first_reg;
            slots_in.c = wide_imm;
         end
      endcase
      valid_in = advance ? req_chan.valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_chan.valid) begin
         slots_ff <= slots_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_slots = slots_ff;

endmodule

// File: hw/rtl/alu3_exec.sv
// alu3_exec: second pipeline stage, applies the opcode to slots a and b
// depends on alu3_pkg

module alu3_exec (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  alu3_pkg::slots_type    in_slots,
   output logic                   in_ready,
   output logic                   out_valid,
   output alu3_pkg::partial_type  out_part,
   input  logic                   out_ready
);

   logic                    valid_ff;
   logic                    valid_in;
   alu3_pkg::partial_type   part_ff;
   alu3_pkg::partial_type   part_in;
   alu3_pkg::word_type      a;
   alu3_pkg::word_type      b;
   logic                    big_amount;
   logic [alu3_pkg::SHAMT_W-1:0] shamt;
   logic                    lt;
   logic                    advance;

   assign advance  = !valid_ff || out_ready;
   assign in_ready = advance;

   always_comb begin
      a          = in_slots.a;
      b          = in_slots.b;
      big_amount = |b[alu3_pkg::DATA_W-1:alu3_pkg::SHAMT_W];
      shamt      = b[alu3_pkg::SHAMT_W-1:0];
      lt         = $signed(a) < $signed(b);
      part_in.c  = in_slots.c;
      unique case (in_slots.op)
         alu3_pkg::OP_ADD:     part_in.val = a + b;
         alu3_pkg::OP_SUB:     part_in.val = a - b;
         alu3_pkg::OP_MUL:     part_in.val = a * b;
         alu3_pkg::OP_SRL:     part_in.val = big_amount ? '0 : (a >> shamt);
         alu3_pkg::OP_SRA: begin
            part_in.val = big_amount ? {alu3_pkg::DATA_W{a[alu3_pkg::DATA_W-1]}}
                                     : alu3_pkg::word_type'($signed(a) >>> shamt);
         end
         alu3_pkg::OP_SLL:     part_in.val = big_amount ? '0 : (a << shamt);
         alu3_pkg::OP_LT:      part_in.val = {alu3_pkg::DATA_W{lt}};
         alu3_pkg::OP_EQ:      part_in.val = {alu3_pkg::DATA_W{a == b}};
         alu3_pkg::OP_GE:      part_in.val = {alu3_pkg::DATA_W{!lt}};
         alu3_pkg::OP_AND:     part_in.val = a & b;
         alu3_pkg::OP_ANDN:    part_in.val = a & ~b;
         alu3_pkg::OP_OR:      part_in.val = a | b;
         alu3_pkg::OP_ORN:     part_in.val = a | ~b;
         alu3_pkg::OP_XOR:     part_in.val = a ^ b;
         alu3_pkg::OP_PACK:    part_in.val = (a << alu3_pkg::PACK_SHIFT) | (b & alu3_pkg::PACK_MASK);
         alu3_pkg::OP_TESTBIT: part_in.val = {alu3_pkg::DATA_W{!big_amount && a[shamt]}};
      endcase
      valid_in = advance ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         part_ff <= part_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_part  = part_ff;

endmodule

// File: hw/rtl/alu3_sum.sv
// alu3_sum: last pipeline stage, adds slot c and holds the result for the response channel
// depends on alu3_pkg and alu3_rsp_if

module alu3_sum (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  alu3_pkg::partial_type  in_part,
   output logic                   in_ready,
   alu3_rsp_if.source             rsp_chan
);

   logic                  valid_ff;
   logic                  valid_in;
   alu3_pkg::word_type    result_ff;
   alu3_pkg::word_type    result_in;
   logic                  advance;

   assign advance  = !valid_ff || rsp_chan.ready;
   assign in_ready = advance;

   always_comb begin
      result_in = in_part.val + in_part.c;
      valid_in  = advance ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         result_ff <= result_in;
      end
   end

   assign rsp_chan.valid  = valid_ff;
   assign rsp_chan.result = result_ff;

endmodule
